FILE: rtl/sbl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sorted bin lookup block.
// No dependencies; every other file but bsl_ram imports this package.
package sbl_pkg;

    localparam int unsigned ENTRY_W       = 11;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned BIN_W         = 10;
    localparam int unsigned COUNT_W       = 11;
    localparam int unsigned DEF_MAX_BINS  = 1024;
    localparam logic [COUNT_W-1:0] BIN_COUNT_RESET = 11'd1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        logic [KEY_W-1:0]   key_value;
    } req_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic             found;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        logic [KEY_W-1:0]   key_value;
    } stage_t;

    function automatic logic index_ok(input logic [ENTRY_W-1:0] idx,
                                      input int unsigned max_bins);
        return 32'(idx) <= max_bins;
    endfunction

endpackage

FILE: rtl/sorted_bin_lookup.sv
`timescale 1ns / 1ps
// Sorted bin lookup: top level with request register, search levels, range check.
// Depends on sbl_pkg, sbl_level, sbl_range and bsl_ram.
//
// Usage:
//   Requests enter on request when start is high and busy is low. busy stays
//   low: a request is taken in every cycle. A load (req_type 0) writes one
//   edge if its index is at most MAX_BINS and gives no result; a lookup
//   (req_type 1) gives one result. The result shows on result for one cycle
//   with done high, in request order. Throughput is one request per cycle.
//   A request passes the request register, then at each search level a probe
//   read and then a lo/hi update (each level owns a copy of the edge table),
//   and then the range check: its edge reads, then the done and result registers.
//   Every load writes each copy as it passes that copy's level, so a lookup
//   sees exactly the loads issued before it.
//   cfg_we/cfg_data write bin_count; write it only while no lookup is in flight.
//   Reset clears bin_count to 1 and empties the pipeline; edge storage is not
//   cleared and holds unknown data until loaded. The receiver cannot stall.
module sorted_bin_lookup #(
    parameter int unsigned MAX_BINS = sbl_pkg::DEF_MAX_BINS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  sbl_pkg::req_t                request,
    output logic                         done,
    output sbl_pkg::rsp_t                result,
    input  logic                         cfg_we,
    input  logic [sbl_pkg::COUNT_W-1:0]  cfg_data
);
    import sbl_pkg::*;

    localparam int unsigned IW     = $clog2(MAX_BINS + 1);
    localparam int unsigned LEVELS = $clog2(MAX_BINS);
    localparam int unsigned LAT    = 2 * LEVELS + 3;

    logic [COUNT_W-1:0] bin_count_reg;
    stage_t             entry_reg;
    logic [IW-1:0]      entry_lo_reg, entry_hi_reg, entry_n_reg;
    logic [IW-1:0]      n_clamp;
    logic               accept;

    stage_t        lv_stage [LEVELS+1];
    logic [IW-1:0] lv_lo    [LEVELS+1];
    logic [IW-1:0] lv_hi    [LEVELS+1];
    logic [IW-1:0] lv_n     [LEVELS+1];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign n_clamp = (32'(bin_count_reg) > MAX_BINS) ? IW'(MAX_BINS) : IW'(bin_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= BIN_COUNT_RESET;
            entry_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bin_count_reg <= cfg_data;
            end
            entry_reg.valid       <= accept;
            entry_reg.req_type    <= request.req_type;
            entry_reg.entry_index <= request.entry_index;
            entry_reg.key_value   <= request.key_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_lo_reg <= '0;
        entry_hi_reg <= (n_clamp == '0) ? '0 : n_clamp - IW'(1);
        entry_n_reg  <= n_clamp;
    end

    assign lv_stage[0] = entry_reg;
    assign lv_lo[0]    = entry_lo_reg;
    assign lv_hi[0]    = entry_hi_reg;
    assign lv_n[0]     = entry_n_reg;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        sbl_level #(
            .MAX_BINS (MAX_BINS)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_stage  (lv_stage[g]),
            .in_lo     (lv_lo[g]),
            .in_hi     (lv_hi[g]),
            .in_n      (lv_n[g]),
            .out_stage (lv_stage[g+1]),
            .out_lo    (lv_lo[g+1]),
            .out_hi    (lv_hi[g+1]),
            .out_n     (lv_n[g+1])
        );
    end

    sbl_range #(
        .MAX_BINS (MAX_BINS)
    ) u_range (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_stage (lv_stage[LEVELS]),
        .in_lo    (lv_lo[LEVELS]),
        .in_n     (lv_n[LEVELS]),
        .done     (done),
        .result   (result)
    );

    a_done_from_lookup : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (request.req_type == REQ_LOOKUP), LAT))
        else $error("result without a matching lookup request");

    a_lookup_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.req_type == REQ_LOOKUP) |-> ##LAT done)
        else $error("lookup request lost");

    a_bin_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> (COUNT_W'(result.bin_index) < bin_count_reg))
        else $error("bin index beyond bin count");

    a_miss_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> (result.bin_index == '0))
        else $error("miss with nonzero bin index");
endmodule

FILE: rtl/bsl_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module bsl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/sbl_level.sv
`timescale 1ns / 1ps
// One binary search level: a private edge copy, a probe and a lo/hi update.
// Depends on sbl_pkg and bsl_ram.
module sbl_level #(
    parameter int unsigned MAX_BINS = sbl_pkg::DEF_MAX_BINS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbl_pkg::stage_t                 in_stage,
    input  logic [$clog2(MAX_BINS+1)-1:0]   in_lo,
    input  logic [$clog2(MAX_BINS+1)-1:0]   in_hi,
    input  logic [$clog2(MAX_BINS+1)-1:0]   in_n,
    output sbl_pkg::stage_t                 out_stage,
    output logic [$clog2(MAX_BINS+1)-1:0]   out_lo,
    output logic [$clog2(MAX_BINS+1)-1:0]   out_hi,
    output logic [$clog2(MAX_BINS+1)-1:0]   out_n
);
    import sbl_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BINS + 1);

    logic [IW:0]      mid_sum;
    logic [IW-1:0]    mid;
    logic             ram_we;
    logic [IW-1:0]    ram_addr;
    logic [KEY_W-1:0] ram_rdata;

    stage_t        b_stage_reg;
    logic [IW-1:0] b_lo_reg, b_hi_reg, b_mid_reg, b_n_reg;
    stage_t        o_stage_reg;
    logic [IW-1:0] o_lo_reg, o_hi_reg, o_n_reg;
    logic [IW-1:0] lo_next, hi_next;

    assign mid_sum  = {1'b0, in_lo} + {1'b0, in_hi} + (IW+1)'(1);
    assign mid      = mid_sum[IW:1];
    assign ram_we   = in_stage.valid && (in_stage.req_type == REQ_LOAD)
                      && index_ok(in_stage.entry_index, MAX_BINS);
    assign ram_addr = (in_stage.req_type == REQ_LOOKUP) ? mid : IW'(in_stage.entry_index);

    bsl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_BINS + 1)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_stage.key_value),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        lo_next = b_lo_reg;
        hi_next = b_hi_reg;
        if (b_lo_reg < b_hi_reg)
        begin
            if (b_stage_reg.key_value >= ram_rdata)
            begin
                lo_next = b_mid_reg;
            end
            else
            begin
                hi_next = b_mid_reg - IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_stage_reg <= '0;
            o_stage_reg <= '0;
        end
        else
        begin
            b_stage_reg <= in_stage;
            o_stage_reg <= b_stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_lo_reg  <= in_lo;
        b_hi_reg  <= in_hi;
        b_mid_reg <= mid;
        b_n_reg   <= in_n;
        o_lo_reg  <= lo_next;
        o_hi_reg  <= hi_next;
        o_n_reg   <= b_n_reg;
    end

    assign out_stage = o_stage_reg;
    assign out_lo    = o_lo_reg;
    assign out_hi    = o_hi_reg;
    assign out_n     = o_n_reg;
endmodule

FILE: rtl/sbl_range.sv
`timescale 1ns / 1ps
// Range check against the first and last edge, and the result register.
// Depends on sbl_pkg and bsl_ram.
module sbl_range #(
    parameter int unsigned MAX_BINS = sbl_pkg::DEF_MAX_BINS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbl_pkg::stage_t               in_stage,
    input  logic [$clog2(MAX_BINS+1)-1:0] in_lo,
    input  logic [$clog2(MAX_BINS+1)-1:0] in_n,
    output logic                          done,
    output sbl_pkg::rsp_t                 result
);
    import sbl_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BINS + 1);

    logic             ram_we;
    logic             is_lookup;
    logic [IW-1:0]    first_addr, last_addr;
    logic [KEY_W-1:0] first_edge, last_edge;

    stage_t        b_stage_reg;
    logic [IW-1:0] b_lo_reg, b_n_reg;
    logic          hit;
    logic          done_reg;
    rsp_t          result_reg;

    assign is_lookup  = (in_stage.req_type == REQ_LOOKUP);
    assign ram_we     = in_stage.valid && !is_lookup
                        && index_ok(in_stage.entry_index, MAX_BINS);
    assign first_addr = is_lookup ? '0   : IW'(in_stage.entry_index);
    assign last_addr  = is_lookup ? in_n : IW'(in_stage.entry_index);

    bsl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_BINS + 1)
    ) u_first_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (first_addr),
        .wdata (in_stage.key_value),
        .rdata (first_edge)
    );

    bsl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_BINS + 1)
    ) u_last_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (last_addr),
        .wdata (in_stage.key_value),
        .rdata (last_edge)
    );

    assign hit = (b_n_reg != '0) && (b_stage_reg.key_value >= first_edge)
                 && (b_stage_reg.key_value < last_edge);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_stage_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            b_stage_reg <= in_stage;
            done_reg    <= b_stage_reg.valid && (b_stage_reg.req_type == REQ_LOOKUP);
        end
    end

    always_ff @(posedge clk)
    begin
        b_lo_reg             <= in_lo;
        b_n_reg              <= in_n;
        result_reg.found     <= hit;
        result_reg.bin_index <= hit ? BIN_W'(b_lo_reg) : '0;
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

FILE: sim/sorted_bin_lookup_tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_bin_lookup: directed and random load/lookup requests, with
// every result checked against a bin-search predictor kept inside this file.
// Depends on sbl_pkg and the sorted_bin_lookup RTL.
module sorted_bin_lookup_tb;
    import sbl_pkg::*;

    localparam int unsigned MAX_BINS         = DEF_MAX_BINS;
    localparam int unsigned LATENCY          = 2 * $clog2(MAX_BINS) + 3;
    localparam int unsigned SETTLE           = LATENCY + 8;
    localparam int unsigned WATCHDOG_LIMIT   = 4000;
    localparam int unsigned SHOWN_MISMATCHES = 10;
    localparam int unsigned RANDOM_ITEMS     = 700;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    req_t               request  = '0;
    logic               done;
    rsp_t               result;
    logic               cfg_we   = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;

    logic [KEY_W-1:0]   edge_mem [0:MAX_BINS];
    logic [KEY_W-1:0]   ramp [0:MAX_BINS];
    logic [COUNT_W-1:0] bin_count_reg = BIN_COUNT_RESET;
    rsp_t               pending_bins [$];

    int idle_pct        = 0;
    int error_count     = 0;
    int results_checked = 0;
    int loads_sent      = 0;
    int loads_ignored   = 0;
    int lookups_sent    = 0;
    int settings_used   = 0;
    int stall_cycles    = 0;

    sorted_bin_lookup #(
        .MAX_BINS (MAX_BINS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic rsp_t search_bin(input logic [KEY_W-1:0] key);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        rsp_t        r;
        n = (bin_count_reg > MAX_BINS) ? MAX_BINS : 32'(bin_count_reg);
        r = '0;
        if (n != 0 && key >= edge_mem[0] && key < edge_mem[n])
        begin
            lo = 0;
            hi = n - 1;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (key >= edge_mem[mid])
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r.bin_index = BIN_W'(lo);
            r.found     = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] lookup_key(input int unsigned used);
        int unsigned      j;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] gap;
        j    = $urandom_range(0, used);
        base = edge_mem[j];
        gap  = (j < used) ? edge_mem[j + 1] - base : '0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return base;
            4, 5:       return base - 1;
            6:          return base + 1;
            7:          return (gap > 1) ? base + $urandom_range(1, gap - 1) : $urandom;
            8:          return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default:    return $urandom;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= SHOWN_MISMATCHES)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic send_request(input logic rt, input logic [ENTRY_W-1:0] idx,
                                input logic [KEY_W-1:0] key);
        req_t item;
        item.req_type    = rt;
        item.entry_index = idx;
        item.key_value   = key;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (rt == REQ_LOOKUP)
        begin
            pending_bins.push_back(search_bin(key));
            lookups_sent++;
        end
        else if (idx <= MAX_BINS)
        begin
            edge_mem[idx] = key;
            loads_sent++;
        end
        else
        begin
            loads_ignored++;
        end
    endtask

    task automatic load_edge(input logic [ENTRY_W-1:0] idx, input logic [KEY_W-1:0] key);
        send_request(REQ_LOAD, idx, key);
    endtask

    task automatic look_up(input logic [KEY_W-1:0] key);
        send_request(REQ_LOOKUP, ENTRY_W'($urandom_range(0, 2047)), key);
    endtask

    task automatic wait_idle;
        start <= 1'b0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_bin_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        bin_count_reg  = value;
        settings_used++;
    endtask

    task automatic restore_ramp;
        for (int i = 0; i <= MAX_BINS; i++)
            if (edge_mem[i] !== ramp[i])
                load_edge(ENTRY_W'(i), ramp[i]);
    endtask

    task automatic build_sorted_table(input int unsigned used);
        int unsigned top;
        longint      max_step;
        longint      v;
        top = (used == 0) ? 1 : used;
        case ($urandom_range(0, 2))
            0:       max_step = 2;
            1:       max_step = 5000;
            default: max_step = 64'hFFFF_FFFF / top;
        endcase
        v = $urandom_range(0, 32'(64'hFFFF_FFFF - top * max_step));
        for (int i = 0; i <= top; i++)
        begin
            load_edge(ENTRY_W'(i), v[KEY_W-1:0]);
            v += $urandom_range(1, 32'(max_step));
        end
    endtask

    task automatic run_random_phase;
        logic [COUNT_W-1:0] cfg;
        logic [KEY_W-1:0]   lo_edge;
        logic [KEY_W-1:0]   hi_edge;
        int unsigned        used;
        int unsigned        lookups;
        int unsigned        pick;
        int unsigned        idx;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            cfg = COUNT_W'($urandom_range(1, 40));
        else if (pick < 75)
            cfg = COUNT_W'($urandom_range(41, 300));
        else if (pick < 83)
            cfg = $urandom_range(0, 1) ? COUNT_W'(MAX_BINS)
                                       : COUNT_W'($urandom_range(MAX_BINS + 1, 2047));
        else if (pick < 90)
            cfg = '0;
        else
            cfg = COUNT_W'($urandom_range(1, 3));
        write_bin_count(cfg);
        used = (cfg > MAX_BINS) ? MAX_BINS : 32'(cfg);
        if (used > 300)
            restore_ramp();
        else
            build_sorted_table(used);
        lookups = $urandom_range(20, 60);
        for (int k = 0; k < lookups; k++)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 8)
            begin
                load_edge(ENTRY_W'($urandom_range(MAX_BINS + 1, 2047)), $urandom);
            end
            else if (pick < 14 && used < MAX_BINS)
            begin
                idx = used + $urandom_range(1, 8);
                load_edge(ENTRY_W'((idx > MAX_BINS) ? MAX_BINS : idx), $urandom);
            end
            else if (pick < 22 && used >= 2)
            begin
                idx     = $urandom_range(1, used - 1);
                lo_edge = edge_mem[idx - 1];
                hi_edge = edge_mem[idx + 1];
                if (hi_edge > lo_edge && hi_edge - lo_edge >= 2)
                    load_edge(ENTRY_W'(idx), lo_edge + $urandom_range(1, hi_edge - lo_edge - 1));
            end
            else if (pick == 22)
            begin
                load_edge(ENTRY_W'($urandom_range(0, used)), $urandom);
            end
            else
            begin
                look_up(lookup_key(used));
            end
        end
    endtask

    task automatic test_table_fill;
        longint v;
        for (int i = 0; i <= MAX_BINS; i++)
        begin
            v       = longint'(i) * 4190000 + $urandom_range(0, 4189999);
            ramp[i] = v[KEY_W-1:0];
            load_edge(ENTRY_W'(i), ramp[i]);
        end
    endtask

    task automatic test_reset_bin_count;
        look_up(ramp[0]);
        look_up(ramp[1] - 1);
        look_up(ramp[1]);
    endtask

    task automatic test_key_extremes;
        write_bin_count(11'd1);
        load_edge(ENTRY_W'(0), 32'h0000_0000);
        load_edge(ENTRY_W'(1), 32'hFFFF_FFFF);
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFE);
        look_up(32'hFFFF_FFFF);
        load_edge(ENTRY_W'(0), 32'h0000_0010);
        look_up(32'h0000_000F);
    endtask

    task automatic test_zero_bins;
        write_bin_count(11'd0);
        look_up(32'h0000_0010);
    endtask

    task automatic test_index_limits;
        load_edge(ENTRY_W'(2047), 32'h0000_0000);
        load_edge(ENTRY_W'(MAX_BINS + 1), 32'h0000_0000);
        ramp[MAX_BINS] = ramp[MAX_BINS] + 1;
        load_edge(ENTRY_W'(MAX_BINS), ramp[MAX_BINS]);
        load_edge(ENTRY_W'(0), ramp[0]);
        load_edge(ENTRY_W'(1), ramp[1]);
        write_bin_count(11'd2047);
        look_up(ramp[MAX_BINS] - 1);
        look_up(ramp[MAX_BINS]);
        look_up(ramp[MAX_BINS / 2]);
        write_bin_count(COUNT_W'(MAX_BINS));
        look_up(ramp[0]);
    endtask

    task automatic test_unsorted_edges;
        write_bin_count(11'd4);
        load_edge(ENTRY_W'(0), 32'd100);
        load_edge(ENTRY_W'(1), 32'd300);
        load_edge(ENTRY_W'(2), 32'd200);
        load_edge(ENTRY_W'(3), 32'd300);
        load_edge(ENTRY_W'(4), 32'd500);
        look_up(32'd250);
        look_up(32'd300);
        look_up(32'd450);
    endtask

    task automatic test_random_traffic(input int pct, input int unsigned target);
        int unsigned first;
        idle_pct = pct;
        first    = loads_sent + lookups_sent;
        while (loads_sent + lookups_sent - first < target)
            run_random_phase();
    endtask

    always @(posedge clk)
    begin : check_result
        rsp_t want;
        if (rst_n && done)
        begin
            results_checked++;
            if (pending_bins.size() == 0)
            begin
                note_failure($sformatf("unexpected result: bin %0d found %0b",
                                       result.bin_index, result.found));
            end
            else
            begin
                want = pending_bins.pop_front();
                if (result.bin_index !== want.bin_index || result.found !== want.found)
                    note_failure($sformatf(
                        "result %0d: expected bin %0d found %0b, got bin %0d found %0b",
                        results_checked, want.bin_index, want.found,
                        result.bin_index, result.found));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request or result for %0d cycles", stall_cycles);
            $display("** sorted_bin_lookup: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 36;
        test_table_fill();
        test_reset_bin_count();
        test_key_extremes();
        test_zero_bins();
        test_index_limits();
        test_unsorted_edges();

        test_random_traffic(36, RANDOM_ITEMS / 3);
        test_random_traffic(54, RANDOM_ITEMS / 3);
        test_random_traffic(0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        wait_idle();
        $display("Covered %0d edge loads (%0d out of range) and %0d lookups over %0d bin counts.",
                 loads_sent, loads_ignored, lookups_sent, settings_used);
        $display("Checked %0d results, %0d failures.", results_checked, error_count);
        if (error_count == 0)
            $display("** sorted_bin_lookup: PASSED **");
        else
            $display("** sorted_bin_lookup: FAILED **");
        $finish;
    end

endmodule
